// ===== src/nfa_bit_vector_matcher_core_defines.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef NFA_BIT_VECTOR_MATCHER_CORE_DEFINES_SVH
`define NFA_BIT_VECTOR_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define NBVM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NBVM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/nbvm_pkg.sv =====
// Package: types, codes and constants of the NFA bit vector matcher.
package nbvm_pkg;

	localparam int NODES     = 64;
	localparam int EDGES     = 2 * NODES;
	localparam int CLS_WORDS = 4 * EDGES;
	localparam int EDGE_AW   = $clog2(EDGES);
	localparam int CLS_AW    = $clog2(CLS_WORDS);
	localparam int CNT_W     = CLS_AW + 1;

	typedef enum logic [1:0] {
		KIND_EDGE  = 2'd0,
		KIND_CLASS = 2'd1,
		KIND_RST   = 2'd2,
		KIND_CHAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOVE,
		ST_CLOSE,
		ST_OUT
	} state_t;

	localparam logic REG_START = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic cnt_clr;
		logic cnt_inc;
		logic clr_wr;
		logic take;
		logic load_wr;
		logic seed;
		logic move_pass;
		logic close_pass;
		logic move_commit;
		logic chg_clr;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic clr_end;
		logic pass_end;
		logic changed;
		logic slot_free;
	} sts_t;

endpackage

// ===== src/nbvm_ctrl.sv =====
// Controller: sequences table clear, move pass and epsilon closure passes.
module nbvm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_acc,
	input  nbvm_pkg::kind_t kind,
	input  nbvm_pkg::sts_t  sts,
	output logic          busy,
	output nbvm_pkg::cmd_t  cmd
);
	import nbvm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_end) state_d = ST_IDLE;
			ST_IDLE: begin
				if (item_acc) begin
					case (kind)
						KIND_RST:  state_d = ST_CLOSE;
						KIND_CHAR: state_d = ST_MOVE;
						default:   state_d = ST_OUT;
					endcase
				end
			end
			ST_MOVE: if (sts.pass_end) state_d = ST_CLOSE;
			ST_CLOSE: if (sts.pass_end && !sts.changed) state_d = ST_OUT;
			ST_OUT: if (sts.slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.cnt_clr = sts.clr_end;
			end
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.cnt_clr = 1'b1;
				cmd.chg_clr = 1'b1;
				if (item_acc) begin
					cmd.take    = 1'b1;
					cmd.load_wr = (kind == KIND_EDGE) || (kind == KIND_CLASS);
					cmd.seed    = (kind == KIND_RST);
				end
			end
			ST_MOVE: begin
				cmd.move_pass   = 1'b1;
				cmd.cnt_inc     = 1'b1;
				cmd.move_commit = sts.pass_end;
				cmd.cnt_clr     = sts.pass_end;
				cmd.chg_clr     = sts.pass_end;
			end
			ST_CLOSE: begin
				cmd.close_pass = 1'b1;
				cmd.cnt_inc    = 1'b1;
				cmd.cnt_clr    = sts.pass_end;
				cmd.chg_clr    = sts.pass_end;
			end
			ST_OUT: cmd.res_load = sts.slot_free;
			default: ;
		endcase
	end

endmodule

// ===== src/nbvm_dpath.sv =====
// Datapath: edge and class memories, active set, pass counter, result register.
module nbvm_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nbvm_pkg::cmd_t          cmd,
	output nbvm_pkg::sts_t          sts,
	input  nbvm_pkg::kind_t         kind,
	input  logic [5:0]              node_index,
	input  logic                    edge_select,
	input  logic [5:0]              edge_target,
	input  logic                    target_valid,
	input  logic                    is_epsilon,
	input  logic [1:0]              word_select,
	input  logic [63:0]             class_bits,
	input  logic [7:0]              char_code,
	input  logic [5:0]              start_node,
	input  logic [6:0]              node_count,
	input  logic                    res_stall,
	output logic                    res_valid,
	output logic [63:0]             res_set
);
	import nbvm_pkg::*;

	logic [7:0]          edge_mem [EDGES];
	logic [63:0]         cls_mem  [CLS_WORDS];
	logic [CNT_W-1:0]    cnt_q;
	logic [63:0]         set_q, nxt_q, res_q;
	logic                chg_q, res_vld_q;
	logic [7:0]          ch_q;
	logic [7:0]          edge_s1;
	logic [63:0]         cls_s1;
	logic [EDGE_AW-1:0]  k_s1;
	logic                v_s1;
	logic [63:0]         use_mask, tbit, set_w, nxt_w;
	logic                active, hit_m, hit_c, in_pass, issue;
	logic [EDGE_AW-1:0]  ld_edge;

	assign use_mask = (node_count >= 7'(NODES)) ? '1 : ((64'd1 << node_count[5:0]) - 64'd1);
	assign in_pass  = cmd.move_pass | cmd.close_pass;
	assign issue    = in_pass && (cnt_q < CNT_W'(EDGES));
	assign ld_edge  = {node_index, edge_select};

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			edge_mem[cnt_q[EDGE_AW-1:0]] <= '0;
		end else if (cmd.load_wr && kind == KIND_EDGE) begin
			edge_mem[ld_edge] <= {is_epsilon, target_valid, edge_target};
		end
		if (cmd.clr_wr) begin
			cls_mem[cnt_q[CLS_AW-1:0]] <= '0;
		end else if (cmd.load_wr && kind == KIND_CLASS) begin
			cls_mem[{ld_edge, word_select}] <= class_bits;
		end
		edge_s1 <= edge_mem[cnt_q[EDGE_AW-1:0]];
		cls_s1  <= cls_mem[{cnt_q[EDGE_AW-1:0], ch_q[7:6]}];
		k_s1    <= cnt_q[EDGE_AW-1:0];
		if (cmd.take) ch_q <= char_code;
		if (cmd.res_load) res_q <= set_q;
	end

	assign active = set_q[k_s1[EDGE_AW-1:1]] & use_mask[k_s1[EDGE_AW-1:1]];
	assign tbit   = (64'd1 << edge_s1[5:0]) & use_mask;
	assign hit_m  = v_s1 && cmd.move_pass && active && edge_s1[6] && !edge_s1[7]
		&& cls_s1[ch_q[5:0]];
	assign hit_c  = v_s1 && cmd.close_pass && active && edge_s1[6] && edge_s1[7];
	assign nxt_w  = nxt_q | (hit_m ? tbit : '0);
	assign set_w  = set_q | (hit_c ? tbit : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			set_q     <= '0;
			nxt_q     <= '0;
			chg_q     <= 1'b0;
			v_s1      <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.seed) begin
				set_q <= (64'd1 << start_node) & use_mask;
			end else if (cmd.move_commit) begin
				set_q <= nxt_w;
			end else if (cmd.close_pass) begin
				set_q <= set_w;
			end
			if (cmd.take) nxt_q <= '0;
			else if (cmd.move_pass) nxt_q <= nxt_w;
			if (cmd.chg_clr) chg_q <= 1'b0;
			else if (set_w != set_q) chg_q <= 1'b1;
			if (cmd.res_load) res_vld_q <= 1'b1;
			else if (!res_stall) res_vld_q <= 1'b0;
		end
	end

	assign sts.clr_end   = (cnt_q == CNT_W'(CLS_WORDS - 1));
	assign sts.pass_end  = (cnt_q == CNT_W'(EDGES));
	assign sts.changed   = chg_q | (set_w != set_q);
	assign sts.slot_free = !res_vld_q || !res_stall;

	assign res_valid = res_vld_q;
	assign res_set   = res_q;

endmodule

// ===== src/nfa_bit_vector_matcher_core.sv =====
// Load items go through the output state only; restart and character items take passes
// over all 128 edges: a character takes 1 move pass plus P closure passes, and restart
// takes P closure passes; P is at most the longest epsilon chain plus one.
// One item at a time; the next item is taken while a result waits in the output register.
// After reset a clear of all 512 class words and the edge memory runs before the first item.
`include "nfa_bit_vector_matcher_core_defines.svh"
module nfa_bit_vector_matcher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  node_index,
	input  logic        edge_select,
	input  logic [5:0]  edge_target,
	input  logic        target_valid,
	input  logic        is_epsilon,
	input  logic [1:0]  word_select,
	input  logic [63:0] class_bits,
	input  logic [7:0]  char_code,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        accepting,
	output logic        alive,
	output logic [63:0] active_set
);
	import nbvm_pkg::*;

	logic [5:0] start_q;
	logic [6:0] count_q;
	logic       busy, item_acc;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 6'd1;
			count_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_START: start_q <= pwdata[5:0];
				REG_COUNT: count_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START: prdata = {26'd0, start_q};
			REG_COUNT: prdata = {25'd0, count_q};
			default:   prdata = '0;
		endcase
	end

	assign item_stall = busy;
	assign item_acc   = item_valid && !busy;

	nbvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_acc (item_acc),
		.kind     (kind_t'(kind)),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	nbvm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind_t'(kind)),
		.node_index   (node_index),
		.edge_select  (edge_select),
		.edge_target  (edge_target),
		.target_valid (target_valid),
		.is_epsilon   (is_epsilon),
		.word_select  (word_select),
		.class_bits   (class_bits),
		.char_code    (char_code),
		.start_node   (start_q),
		.node_count   (count_q),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.res_set      (active_set)
	);

	assign accepting = active_set[0];
	assign alive     = |active_set;

	`NBVM_ASSERT_NXT(a_busy_after_acc, item_acc, item_stall, "accepted transaction did not block input")
	`NBVM_ASSERT_NXT(a_res_after_load, cmd.res_load, res_valid, "result load lost")
	`NBVM_ASSERT_IMP(a_one_pass, cmd.move_pass, !cmd.close_pass, "move and closure pass overlap")

endmodule

// ===== dv/nfa_bit_vector_matcher_core_test.sv =====
// Self-checking testbench of the NFA bit vector matcher: directed table, then random phases.
module nfa_bit_vector_matcher_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nbvm_pkg::*;

	localparam int LIMIT = 20000000;
	localparam int HOLD  = 3000;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  node;
		logic        sel;
		logic [5:0]  tgt;
		logic        tv;
		logic        eps;
		logic [1:0]  ws;
		logic [63:0] bits;
		logic [7:0]  ch;
		logic        chk;
		logic [63:0] want;
	} nfa_item_t;

	typedef struct packed {
		logic        acc;
		logic        alv;
		logic [63:0] set;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] kind = '0;
	logic [5:0] node_index = '0;
	logic edge_select = 1'b0;
	logic [5:0] edge_target = '0;
	logic target_valid = 1'b0;
	logic is_epsilon = 1'b0;
	logic [1:0] word_select = '0;
	logic [63:0] class_bits = '0;
	logic [7:0] char_code = '0;
	logic res_valid;
	logic res_stall = 1'b1;
	logic accepting, alive;
	logic [63:0] active_set;

	nfa_bit_vector_matcher_core dut (.*);

	always #2 clk = ~clk;

	// shadow of the matcher state
	logic [63:0] act_nodes;
	logic [5:0]  tgt_mem [128];
	logic [1:0]  mark_mem [128];
	logic [63:0] cls_mem [512];
	logic [5:0]  start_reg;
	logic [6:0]  count_reg;

	match_t match_q[$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	function automatic logic [63:0] in_use();
		int n;
		n = (count_reg > 64) ? 64 : count_reg;
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic logic [63:0] eps_close(logic [63:0] s, logic [63:0] m);
		logic [63:0] p;
		s &= m;
		do begin
			p = s;
			for (int n = 0; n < 64; n++)
				if (s[n])
					for (int e = 0; e < 2; e++)
						if (mark_mem[2*n+e] == 2'b11)
							s |= (64'd1 << tgt_mem[2*n+e]) & m;
		end while (s != p);
		return s;
	endfunction

	function automatic logic [63:0] step_on(logic [63:0] s, logic [7:0] c, logic [63:0] m);
		logic [63:0] nx;
		int k;
		nx = '0;
		s &= m;
		for (int n = 0; n < 64; n++)
			if (s[n])
				for (int e = 0; e < 2; e++) begin
					k = 2*n + e;
					if (mark_mem[k] == 2'b01 && cls_mem[4*k + c[7:6]][c[5:0]])
						nx |= (64'd1 << tgt_mem[k]) & m;
				end
		return nx;
	endfunction

	function automatic logic [63:0] predict_set(nfa_item_t it);
		logic [63:0] m;
		m = in_use();
		case (it.kind)
			KIND_EDGE: begin
				tgt_mem[2*it.node+it.sel] = it.tgt;
				mark_mem[2*it.node+it.sel] = {it.eps, it.tv};
			end
			KIND_CLASS: cls_mem[4*(2*it.node+it.sel) + it.ws] = it.bits;
			KIND_RST: act_nodes = eps_close((64'd1 << start_reg) & m, m);
			default: act_nodes = eps_close(step_on(act_nodes, it.ch, m), m);
		endcase
		return act_nodes;
	endfunction

	function automatic nfa_item_t mk(kind_t k, logic [5:0] n, logic s, logic [5:0] t, logic tv,
			logic ep, logic [1:0] w, logic [63:0] b, logic [7:0] c, logic chk, logic [63:0] want);
		nfa_item_t it;
		it = '{k, n, s, t, tv, ep, w, b, c, chk, want};
		return it;
	endfunction

	task automatic reg_write(logic [2:0] addr, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		if (addr == 3'd4 * REG_START) start_reg = val[5:0];
		else count_reg = val[6:0];
	endtask

	task automatic set_config(logic [5:0] st, logic [6:0] cnt);
		reg_write(3'd4 * REG_START, {$urandom} << 6 | st);
		reg_write(3'd4 * REG_COUNT, {$urandom} << 7 | cnt);
	endtask

	task automatic send(nfa_item_t it);
		int gap;
		logic [63:0] s;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		kind = it.kind; node_index = it.node; edge_select = it.sel; edge_target = it.tgt;
		target_valid = it.tv; is_epsilon = it.eps; word_select = it.ws; class_bits = it.bits;
		char_code = it.ch; item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		s = predict_set(it);
		if (it.chk) s = it.want;
		match_q.push_back('{s[0], |s, s});
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid = 1'b0;
		while (match_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic nfa_item_t rand_item();
		nfa_item_t it;
		int r;
		it = '0;
		r = $urandom_range(0, 99);
		it.kind = r < 30 ? KIND_EDGE : r < 55 ? KIND_CLASS : r < 65 ? KIND_RST : KIND_CHAR;
		it.node = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
		it.sel = 1'($urandom);
		it.tgt = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
		it.tv = $urandom_range(0, 7) != 0;
		it.eps = $urandom_range(0, 3) == 0;
		it.ws = 2'($urandom);
		case ($urandom_range(0, 3))
			0: it.bits = '1;
			1: it.bits = 64'd1 << $urandom_range(0, 63);
			default: it.bits = rnd64();
		endcase
		it.ch = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(8'h60, 8'h63));
		return it;
	endfunction

	always @(posedge clk) begin
		match_t w;
		if (res_valid && !res_stall) begin
			if (match_q.size() == 0) begin
				$error("result with no expectation: active_set %h", active_set);
				errors++;
			end else begin
				w = match_q.pop_front();
				if (accepting !== w.acc) begin
					$error("accepting: expected %b actual %b", w.acc, accepting);
					errors++;
				end
				if (alive !== w.alv) begin
					$error("alive: expected %b actual %b", w.alv, alive);
					errors++;
				end
				if (active_set !== w.set) begin
					$error("active_set: expected %h actual %h", w.set, active_set);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("nfa_bit_vector_matcher_core verification failed");
			$finish;
		end
	end

	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				res_stall = 1'b1;
				repeat (HOLD) @(negedge clk);
			end
			n = idle_on ? $urandom_range(0, 11) : 0;
			if (n > 0) begin
				@(negedge clk);
				res_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			res_stall = 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	nfa_item_t dir_tab [23];
	logic [5:0] ph_start [8] = '{6'd1, 6'd63, 6'd0, 6'd3, 6'd1, 6'd2, 6'd7, 6'd60};
	logic [6:0] ph_count [8] = '{7'd64, 7'd64, 7'd64, 7'd8, 7'd1, 7'd0, 7'd127, 7'd64};

	initial begin
		act_nodes = '0;
		start_reg = 6'd1;
		count_reg = 7'd64;
		for (int i = 0; i < 128; i++) begin
			tgt_mem[i] = '0;
			mark_mem[i] = '0;
		end
		for (int i = 0; i < 512; i++) cls_mem[i] = '0;

		dir_tab[0]  = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'h00, 1, 64'h0);
		dir_tab[1]  = mk(KIND_RST,   0, 0,  0, 0, 0, 0, 0, 0, 1, 64'h2);
		dir_tab[2]  = mk(KIND_EDGE,  1, 0,  0, 1, 0, 0, 0, 0, 1, 64'h2);
		dir_tab[3]  = mk(KIND_CLASS, 1, 0,  0, 0, 0, 1, 64'd1 << 33, 0, 1, 64'h2);
		dir_tab[4]  = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'h61, 1, 64'h1);
		dir_tab[5]  = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'h61, 1, 64'h0);
		dir_tab[6]  = mk(KIND_RST,   0, 0,  0, 0, 0, 0, 0, 0, 1, 64'h2);
		dir_tab[7]  = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'h62, 1, 64'h0);
		dir_tab[8]  = mk(KIND_EDGE, 63, 1, 63, 1, 1, 0, 0, 0, 1, 64'h0);
		dir_tab[9]  = mk(KIND_CLASS, 63, 1, 0, 0, 0, 3, '1, 0, 1, 64'h0);
		dir_tab[10] = mk(KIND_EDGE,  1, 1, 63, 1, 1, 0, 0, 0, 1, 64'h0);
		dir_tab[11] = mk(KIND_RST,   0, 0,  0, 0, 0, 0, 0, 0, 1, 64'h8000_0000_0000_0002);
		dir_tab[12] = mk(KIND_CLASS, 63, 0, 0, 0, 0, 3, '1, 0, 0, 0);
		dir_tab[13] = mk(KIND_EDGE, 63, 0,  0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[14] = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'hff, 1, 64'h0);
		dir_tab[15] = mk(KIND_EDGE, 63, 0,  0, 1, 0, 0, 0, 0, 0, 0);
		dir_tab[16] = mk(KIND_RST,   0, 0,  0, 0, 0, 0, 0, 0, 1, 64'h8000_0000_0000_0002);
		dir_tab[17] = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'hff, 1, 64'h1);
		dir_tab[18] = mk(KIND_CLASS, 0, 0,  0, 0, 0, 0, '1, 0, 0, 0);
		dir_tab[19] = mk(KIND_EDGE,  0, 0, 62, 1, 0, 0, 0, 0, 0, 0);
		dir_tab[20] = mk(KIND_CHAR,  0, 0,  0, 0, 0, 0, 0, 8'h00, 0, 0);
		dir_tab[21] = mk(KIND_EDGE, 62, 1,  1, 1, 1, 0, 0, 0, 0, 0);
		dir_tab[22] = mk(KIND_RST,   0, 0,  0, 0, 0, 0, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (600) @(posedge clk);

		set_config(6'd1, 7'd64);
		foreach (dir_tab[i]) send(dir_tab[i]);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_config(ph_start[p], ph_count[p]);
			idle_on = (p % 3) != 2;
			if (p == 1) hold_req = 1'b1;
			repeat (205) send(rand_item());
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && match_q.size() == 0)
			$display("nfa_bit_vector_matcher_core verification clean");
		else
			$display("nfa_bit_vector_matcher_core verification failed");
		$finish;
	end
endmodule
